>>> design/tpfv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpfv_pkg;

   localparam int COORD_WIDTH_DEF      = 20;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // Register stages in each part of the pipeline (the root stepper has
   // NORMAL_FRAC_BITS + 1 of its own).
   localparam int CROSS_STAGES  = 3;
   localparam int SQUARE_STAGES = 3;
   localparam int OFFSET_STAGES = 2;

   // Magnitude width of one cross product component.
   function automatic int cross_mag_width(input int coord_width);
      return 2 * coord_width + 1;
   endfunction

endpackage
`default_nettype wire

>>> design/triangle_plane_from_vertices.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the cross, square, unit and offset parts in turn
// and leaves with the result strobe.
// Throughput: one item per cycle; busy is low except during reset and the
// edge after it, and the receiver cannot stall the result strobe.
// Reset (synchronous, active high) clears every valid bit; no data is cleared.
module triangle_plane_from_vertices import tpfv_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_a_z,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_b_z,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_x,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_y,
   input  logic [COORD_WIDTH-1:0]        req_vertex_c_z,
   output logic                          rsp_strobe,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_x,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_y,
   output logic [NORMAL_FRAC_BITS+1:0]   rsp_normal_z,
   output logic [COORD_WIDTH:0]          rsp_plane_offset,
   output logic                          rsp_degenerate
);

   // The work runs through four parts. The cross stage forms the edges, their
   // partial products and the exact cross product as sign and magnitude.
   // The square stage squares each component from half-width partial
   // products and adds the squared length. The unit stage finds every
   // normal component one bit per stage, highest first, keeping the exact
   // remainder so that each component is the true quotient rounded toward
   // zero. The offset stage applies the signs and forms the dot product
   // with vertex a, again rounded toward zero.

   localparam int CMW     = cross_mag_width(COORD_WIDTH);
   localparam int SQW     = 2 * CMW;
   localparam int SW      = SQW + 2;
   localparam int QW      = NORMAL_FRAC_BITS + 1;
   localparam int NW      = NORMAL_FRAC_BITS + 2;
   localparam int LATENCY = CROSS_STAGES + SQUARE_STAGES + NORMAL_FRAC_BITS + 1
                          + OFFSET_STAGES;
   localparam int NORMAL_ONE = 1 << NORMAL_FRAC_BITS;

   logic                        busy_ff, busy_in;
   logic                        accept;
   logic [2:0][COORD_WIDTH-1:0] vert_a, vert_b, vert_c;

   logic                        cr_valid;
   logic [2:0][COORD_WIDTH-1:0] cr_a;
   logic [2:0][CMW-1:0]         cr_mag;
   logic [2:0]                  cr_neg;

   logic                        sq_valid;
   logic [2:0][COORD_WIDTH-1:0] sq_a;
   logic [2:0][SQW-1:0]         sq_sq;
   logic [SW-1:0]               sq_sum;
   logic [2:0]                  sq_neg;
   logic                        sq_deg;

   logic                        un_valid;
   logic [2:0][COORD_WIDTH-1:0] un_a;
   logic [2:0][QW-1:0]          un_q;
   logic [2:0]                  un_neg;
   logic                        un_deg;

   logic [2:0][NW-1:0]          normal;

   // The pipeline never stalls, so busy only covers the reset period.
   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   assign vert_a = {req_vertex_a_z, req_vertex_a_y, req_vertex_a_x};
   assign vert_b = {req_vertex_b_z, req_vertex_b_y, req_vertex_b_x};
   assign vert_c = {req_vertex_c_z, req_vertex_c_y, req_vertex_c_x};

   tpfv_cross #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .out_valid (cr_valid),
      .out_a     (cr_a),
      .out_mag   (cr_mag),
      .out_neg   (cr_neg)
   );

   tpfv_square #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid),
      .in_a      (cr_a),
      .in_mag    (cr_mag),
      .in_neg    (cr_neg),
      .out_valid (sq_valid),
      .out_a     (sq_a),
      .out_sq    (sq_sq),
      .out_sum   (sq_sum),
      .out_neg   (sq_neg),
      .out_deg   (sq_deg)
   );

   tpfv_unit #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_a      (sq_a),
      .in_sq     (sq_sq),
      .in_sum    (sq_sum),
      .in_neg    (sq_neg),
      .in_deg    (sq_deg),
      .out_valid (un_valid),
      .out_a     (un_a),
      .out_q     (un_q),
      .out_neg   (un_neg),
      .out_deg   (un_deg)
   );

   tpfv_offset #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_offset (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (un_valid),
      .in_a       (un_a),
      .in_q       (un_q),
      .in_neg     (un_neg),
      .in_deg     (un_deg),
      .out_valid  (rsp_strobe),
      .out_normal (normal),
      .out_offset (rsp_plane_offset),
      .out_deg    (rsp_degenerate)
   );

   assign rsp_normal_x = normal[0];
   assign rsp_normal_y = normal[1];
   assign rsp_normal_z = normal[2];

   // Every accepted item comes out after the fixed pipeline latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("item did not come out after the pipeline latency");

   // A degenerate triangle gives an all-zero result.
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0 &&
         rsp_plane_offset == '0)
      else $error("degenerate item with non-zero result");

   // No component of a unit normal exceeds one.
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         $signed(rsp_normal_x) <= NORMAL_ONE && $signed(rsp_normal_x) >= -NORMAL_ONE &&
         $signed(rsp_normal_y) <= NORMAL_ONE && $signed(rsp_normal_y) >= -NORMAL_ONE &&
         $signed(rsp_normal_z) <= NORMAL_ONE && $signed(rsp_normal_z) >= -NORMAL_ONE)
      else $error("normal component out of range");

endmodule
`default_nettype wire

>>> design/tpfv_cross.sv
`timescale 1ns / 1ps
`default_nettype none
module tpfv_cross import tpfv_pkg::*; #(
   parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int CMW         = cross_mag_width(COORD_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [2:0][COORD_WIDTH-1:0] vert_a,
   input  logic [2:0][COORD_WIDTH-1:0] vert_b,
   input  logic [2:0][COORD_WIDTH-1:0] vert_c,
   output logic                        out_valid,
   output logic [2:0][COORD_WIDTH-1:0] out_a,
   output logic [2:0][CMW-1:0]         out_mag,
   output logic [2:0]                  out_neg
);

   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;

   logic                        v1_ff, v2_ff, v3_ff;
   logic [2:0][COORD_WIDTH-1:0] a1_ff, a2_ff, a3_ff;
   logic signed [EW-1:0]        e1_ff [3];
   logic signed [EW-1:0]        e2_ff [3];
   logic signed [EW-1:0]        e1_in [3];
   logic signed [EW-1:0]        e2_in [3];
   logic signed [PW-1:0]        p_ff  [6];
   logic signed [PW-1:0]        p_in  [6];
   logic [2:0][CMW-1:0]         mag_ff, mag_in;
   logic [2:0]                  neg_ff, neg_in;

   // Edge vectors b - a and c - a, exact in one extra bit.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = $signed(vert_b[i]) - $signed(vert_a[i]);
         e2_in[i] = $signed(vert_c[i]) - $signed(vert_a[i]);
      end
   end

   // The six partial products of the cross product.
   always_comb begin
      p_in[0] = e1_ff[1] * e2_ff[2];
      p_in[1] = e1_ff[2] * e2_ff[1];
      p_in[2] = e1_ff[2] * e2_ff[0];
      p_in[3] = e1_ff[0] * e2_ff[2];
      p_in[4] = e1_ff[0] * e2_ff[1];
      p_in[5] = e1_ff[1] * e2_ff[0];
   end

   // Difference, then sign and magnitude.
   always_comb begin
      logic signed [PW:0] d;
      logic [PW:0]        m;
      for (int i = 0; i < 3; i++) begin
         d         = p_ff[2*i] - p_ff[2*i+1];
         m         = d[PW] ? -d : d;
         mag_in[i] = m[CMW-1:0];
         neg_in[i] = d[PW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff  <= vert_a;
      a2_ff  <= a1_ff;
      a3_ff  <= a2_ff;
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      p_ff   <= p_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   assign out_valid = v3_ff;
   assign out_a     = a3_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule
`default_nettype wire

>>> design/tpfv_square.sv
`timescale 1ns / 1ps
`default_nettype none
module tpfv_square import tpfv_pkg::*; #(
   parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int CMW         = cross_mag_width(COORD_WIDTH),
   localparam int SQW         = 2 * CMW,
   localparam int SW          = SQW + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [2:0][COORD_WIDTH-1:0] in_a,
   input  logic [2:0][CMW-1:0]         in_mag,
   input  logic [2:0]                  in_neg,
   output logic                        out_valid,
   output logic [2:0][COORD_WIDTH-1:0] out_a,
   output logic [2:0][SQW-1:0]         out_sq,
   output logic [SW-1:0]               out_sum,
   output logic [2:0]                  out_neg,
   output logic                        out_deg
);

   localparam int HW  = (CMW + 1) / 2;
   localparam int HIW = CMW - HW;

   logic                        v4_ff, v5_ff, v6_ff;
   logic [2:0][COORD_WIDTH-1:0] a4_ff, a5_ff, a6_ff;
   logic [2:0]                  n4_ff, n5_ff, n6_ff;
   logic                        d4_ff, d5_ff, d6_ff;
   logic [2:0][2*HIW-1:0]       hh_ff, hh_in;
   logic [2:0][CMW-1:0]         hl_ff, hl_in;
   logic [2:0][2*HW-1:0]        ll_ff, ll_in;
   logic [2:0][SQW-1:0]         sq5_ff, sq5_in, sq6_ff;
   logic [SW-1:0]               sum_ff, sum_in;

   // Each square is split into partial products of half width.
   always_comb begin
      logic [HIW-1:0] hi;
      logic [HW-1:0]  lo;
      for (int i = 0; i < 3; i++) begin
         hi       = in_mag[i][CMW-1:HW];
         lo       = in_mag[i][HW-1:0];
         hh_in[i] = hi * hi;
         hl_in[i] = hi * lo;
         ll_in[i] = lo * lo;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq5_in[i] = (SQW'(hh_ff[i]) << (2 * HW)) + (SQW'(hl_ff[i]) << (HW + 1))
                   + SQW'(ll_ff[i]);
      end
      sum_in = SW'(sq5_ff[0]) + SW'(sq5_ff[1]) + SW'(sq5_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      a4_ff  <= in_a;
      a5_ff  <= a4_ff;
      a6_ff  <= a5_ff;
      n4_ff  <= in_neg;
      n5_ff  <= n4_ff;
      n6_ff  <= n5_ff;
      d4_ff  <= (in_mag == '0);
      d5_ff  <= d4_ff;
      d6_ff  <= d5_ff;
      hh_ff  <= hh_in;
      hl_ff  <= hl_in;
      ll_ff  <= ll_in;
      sq5_ff <= sq5_in;
      sq6_ff <= sq5_ff;
      sum_ff <= sum_in;
   end

   assign out_valid = v6_ff;
   assign out_a     = a6_ff;
   assign out_sq    = sq6_ff;
   assign out_sum   = sum_ff;
   assign out_neg   = n6_ff;
   assign out_deg   = d6_ff;

endmodule
`default_nettype wire

>>> design/tpfv_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tpfv_unit import tpfv_pkg::*; #(
   parameter  int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter  int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
   localparam int CMW              = cross_mag_width(COORD_WIDTH),
   localparam int SQW              = 2 * CMW,
   localparam int SW               = SQW + 2,
   localparam int QW               = NORMAL_FRAC_BITS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [2:0][COORD_WIDTH-1:0] in_a,
   input  logic [2:0][SQW-1:0]         in_sq,
   input  logic [SW-1:0]               in_sum,
   input  logic [2:0]                  in_neg,
   input  logic                        in_deg,
   output logic                        out_valid,
   output logic [2:0][COORD_WIDTH-1:0] out_a,
   output logic [2:0][QW-1:0]          out_q,
   output logic [2:0]                  out_neg,
   output logic                        out_deg
);

   localparam int F  = NORMAL_FRAC_BITS;
   localparam int N  = F + 1;
   localparam int TW = SW + 2 * F + 3;

   // Per stage and lane: remainder r = c^2 * 2^(2F) - q^2 * S and y = q * S,
   // so that trying a further bit of q needs shifts and adds only.
   logic                        v_ff   [N];
   logic [2:0][COORD_WIDTH-1:0] a_ff   [N];
   logic [SW-1:0]               s_ff   [N];
   logic [2:0]                  neg_ff [N];
   logic                        deg_ff [N];
   logic [2:0][TW-1:0]          r_ff   [N];
   logic [2:0][TW-1:0]          y_ff   [N];
   logic [2:0][QW-1:0]          q_ff   [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int B = F - k;

      logic                        pv_v;
      logic [2:0][COORD_WIDTH-1:0] pv_a;
      logic [SW-1:0]               pv_s;
      logic [2:0]                  pv_neg;
      logic                        pv_deg;
      logic [2:0][TW-1:0]          pv_r, pv_y, r_in, y_in;
      logic [2:0][QW-1:0]          pv_q, q_in;

      if (k == 0) begin : g_first
         always_comb begin
            pv_v   = in_valid;
            pv_a   = in_a;
            pv_s   = in_sum;
            pv_neg = in_neg;
            pv_deg = in_deg;
            for (int j = 0; j < 3; j++) begin
               pv_r[j] = TW'(in_sq[j]) << (2 * F);
               pv_y[j] = '0;
               pv_q[j] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            pv_v   = v_ff[k-1];
            pv_a   = a_ff[k-1];
            pv_s   = s_ff[k-1];
            pv_neg = neg_ff[k-1];
            pv_deg = deg_ff[k-1];
            pv_r   = r_ff[k-1];
            pv_y   = y_ff[k-1];
            pv_q   = q_ff[k-1];
         end
      end

      // (q + 2^B)^2 * S = q^2 * S + (y << (B + 1)) + (S << 2B)
      always_comb begin
         logic [TW-1:0] t;
         for (int j = 0; j < 3; j++) begin
            t = (pv_y[j] << (B + 1)) + (TW'(pv_s) << (2 * B));
            if (t <= pv_r[j]) begin
               r_in[j] = pv_r[j] - t;
               y_in[j] = pv_y[j] + (TW'(pv_s) << B);
               q_in[j] = pv_q[j] | (QW'(1) << B);
            end else begin
               r_in[j] = pv_r[j];
               y_in[j] = pv_y[j];
               q_in[j] = pv_q[j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= pv_v;
         end
      end

      always_ff @(posedge clock) begin
         a_ff[k]   <= pv_a;
         s_ff[k]   <= pv_s;
         neg_ff[k] <= pv_neg;
         deg_ff[k] <= pv_deg;
         r_ff[k]   <= r_in;
         y_ff[k]   <= y_in;
         q_ff[k]   <= q_in;
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_a     = a_ff[N-1];
   assign out_q     = q_ff[N-1];
   assign out_neg   = neg_ff[N-1];
   assign out_deg   = deg_ff[N-1];

   // A component of full length leaves no room for any lower bit.
   a_full_len_x: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_deg && out_q[0][QW-1] |-> out_q[0][QW-2:0] == '0)
      else $error("x component above one");
   a_full_len_z: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_deg && out_q[2][QW-1] |-> out_q[2][QW-2:0] == '0)
      else $error("z component above one");
   // The largest component of a unit vector is at least one over root three.
   a_not_null: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_deg |-> (out_q[0] | out_q[1] | out_q[2]) != '0)
      else $error("non-degenerate normal came out null");

endmodule
`default_nettype wire

>>> design/tpfv_offset.sv
`timescale 1ns / 1ps
`default_nettype none
module tpfv_offset import tpfv_pkg::*; #(
   parameter  int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter  int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF,
   localparam int QW               = NORMAL_FRAC_BITS + 1,
   localparam int NW               = NORMAL_FRAC_BITS + 2,
   localparam int OW               = COORD_WIDTH + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [2:0][COORD_WIDTH-1:0] in_a,
   input  logic [2:0][QW-1:0]          in_q,
   input  logic [2:0]                  in_neg,
   input  logic                        in_deg,
   output logic                        out_valid,
   output logic [2:0][NW-1:0]          out_normal,
   output logic [OW-1:0]               out_offset,
   output logic                        out_deg
);

   localparam int F  = NORMAL_FRAC_BITS;
   localparam int MW = COORD_WIDTH + NW;
   localparam int DW = MW + 2;

   logic                 v1_ff, v2_ff;
   logic                 d1_ff, d2_ff;
   logic [2:0][NW-1:0]   n1_ff, n1_in, n2_ff;
   logic signed [MW-1:0] prod_ff [3];
   logic signed [MW-1:0] prod_in [3];
   logic [OW-1:0]        off_ff, off_in;

   // Signed normal, forced to zero for a degenerate triangle, times vertex a.
   always_comb begin
      logic signed [NW-1:0] qs;
      logic signed [NW-1:0] ns;
      for (int i = 0; i < 3; i++) begin
         qs         = $signed({1'b0, in_q[i]});
         ns         = in_deg ? '0 : (in_neg[i] ? -qs : qs);
         n1_in[i]   = ns;
         prod_in[i] = $signed(in_a[i]) * ns;
      end
   end

   // Sum of products, then division by 2^F rounded toward zero.
   always_comb begin
      logic signed [DW-1:0] dot;
      logic signed [DW-1:0] adj;
      logic signed [DW-1:0] sh;
      dot    = prod_ff[0] + prod_ff[1] + prod_ff[2];
      adj    = dot[DW-1] ? dot + $signed({{(DW-F){1'b0}}, {F{1'b1}}}) : dot;
      sh     = adj >>> F;
      off_in = sh[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff   <= in_deg;
      d2_ff   <= d1_ff;
      n1_ff   <= n1_in;
      n2_ff   <= n1_ff;
      prod_ff <= prod_in;
      off_ff  <= off_in;
   end

   assign out_valid  = v2_ff;
   assign out_normal = n2_ff;
   assign out_offset = off_ff;
   assign out_deg    = d2_ff;

endmodule
`default_nettype wire
